>>> rtl/array_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Shared concurrent-assertion wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define APQ_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger
`define APQ_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Commands, status codes and shared types of the array priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apq_pkg;

   localparam int DATA_W      = 32;
   localparam int ENTRY_W     = 2 * DATA_W;
   localparam int CMD_W       = 2;
   localparam int COUNT_OUT_W = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_EMPTY    = 2'd2
   } status_type;

   // Control of one scan beat into the winner tracker
   typedef struct packed {
      logic load;   // read data of a held entry is present
      logic first;  // entry zero, restart the search
   } scan_ctrl_type;

endpackage

>>> rtl/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, and register one read entry, which appears in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/apq_scan.sv
// ----------------------------------------------------------------------------
// apq_scan
// Winner tracker: keeps the highest-priority entry seen during a scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apq_scan #(
   parameter int IDX_W = 4
) (
   input  logic                              clock,
   input  apq_pkg::scan_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]                  idx,
   input  logic signed [apq_pkg::DATA_W-1:0] value,
   input  logic signed [apq_pkg::DATA_W-1:0] priority_in,
   output logic [IDX_W-1:0]                  best_idx,
   output logic signed [apq_pkg::DATA_W-1:0] best_value,
   output logic signed [apq_pkg::DATA_W-1:0] best_priority
);

   logic [IDX_W-1:0]                  best_idx_ff;
   logic signed [apq_pkg::DATA_W-1:0] best_value_ff;
   logic signed [apq_pkg::DATA_W-1:0] best_priority_ff;
   logic                              take;

   // Replace only on strictly larger priority so the oldest entry wins ties
   assign take = ctrl.load && (ctrl.first || (priority_in > best_priority_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff      <= idx;
         best_value_ff    <= value;
         best_priority_ff <= priority_in;
      end
   end

   assign best_idx      = best_idx_ff;
   assign best_value    = best_value_ff;
   assign best_priority = best_priority_ff;

endmodule

>>> rtl/array_priority_queue.sv
// ----------------------------------------------------------------------------
// array_priority_queue
// Unsorted array priority queue: append on enqueue, linear scan for the
// highest priority on dequeue and peek, then on dequeue shift later entries down.
// ----------------------------------------------------------------------------
//
//   Channel  Prefix  Direction  Beat contents
//   -------  ------  ---------  -------------------------------------------
//   request  req_    in         cmd, item_value, item_priority
//   result   rsp_    out        status, out_value, out_priority, entry_count
//
// Enqueue and every empty or full case go straight to completion. Peek and
// dequeue make one RAM read per held entry during the scan; dequeue then
// makes one read and one write per moved entry.
// Reset clears the count and the control; entries need no clearing pass.
// A new request is taken as soon as the previous one has finished, even
// while its result still waits in the output register under rsp_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_priority_queue_assert.svh"

module array_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [apq_pkg::CMD_W-1:0]              req_cmd,
   input  logic signed [apq_pkg::DATA_W-1:0]      req_item_value,
   input  logic signed [apq_pkg::DATA_W-1:0]      req_item_priority,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [apq_pkg::DATA_W-1:0]      rsp_out_value,
   output logic signed [apq_pkg::DATA_W-1:0]      rsp_out_priority,
   output logic [apq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_PICK  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 issued_ff, issued_in;
   logic [IDX_W-1:0]     issued_idx_ff, issued_idx_in;
   logic                 is_deq_ff, is_deq_in;
   logic                 res_take_ff, res_take_in;
   apq_pkg::status_type  res_status_ff, res_status_in;

   logic                              rsp_valid_ff;
   logic [1:0]                        rsp_status_ff;
   logic signed [apq_pkg::DATA_W-1:0] rsp_value_ff;
   logic signed [apq_pkg::DATA_W-1:0] rsp_priority_ff;
   logic [apq_pkg::COUNT_OUT_W-1:0]   rsp_count_ff;

   logic                         req_fire;
   logic                         out_free;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic [apq_pkg::ENTRY_W-1:0]  rd_data;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [apq_pkg::ENTRY_W-1:0]  wr_data;
   logic                         enq_write;
   logic                         scan_done;
   logic                         shift_done;
   apq_pkg::scan_ctrl_type       scan_ctrl;
   logic [IDX_W-1:0]             best_idx;
   logic signed [apq_pkg::DATA_W-1:0] best_value;
   logic signed [apq_pkg::DATA_W-1:0] best_priority;

   // Handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Read port: walk held entries during scan and shift
   assign rd_en   = ((state_ff == S_SCAN) || (state_ff == S_SHIFT)) && (rd_ptr_ff < cnt_ff);
   assign rd_addr = rd_ptr_ff[IDX_W-1:0];

   assign scan_done  = (state_ff == S_SCAN) && issued_ff &&
                       (CNT_W'(issued_idx_ff) == (cnt_ff - CNT_W'(1)));
   assign shift_done = (state_ff == S_SHIFT) && !rd_en && !issued_ff;

   // Write port: append on enqueue, move an entry down during shift
   assign enq_write = req_fire && (req_cmd == apq_pkg::CMD_ENQ) &&
                      (cnt_ff < CNT_W'(QUEUE_DEPTH));
   assign wr_en     = enq_write || ((state_ff == S_SHIFT) && issued_ff);
   assign wr_addr   = enq_write ? cnt_ff[IDX_W-1:0] : (issued_idx_ff - IDX_W'(1));
   assign wr_data   = enq_write ? {req_item_value, req_item_priority} : rd_data;

   apq_ram #(
      .WIDTH (apq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Feed scan beats into the winner tracker
   assign scan_ctrl.load  = (state_ff == S_SCAN) && issued_ff;
   assign scan_ctrl.first = (issued_idx_ff == '0);

   apq_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock         (clock),
      .ctrl          (scan_ctrl),
      .idx           (issued_idx_ff),
      .value         (rd_data[apq_pkg::ENTRY_W-1:apq_pkg::DATA_W]),
      .priority_in   (rd_data[apq_pkg::DATA_W-1:0]),
      .best_idx      (best_idx),
      .best_value    (best_value),
      .best_priority (best_priority)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_ptr_in     = rd_en ? (rd_ptr_ff + CNT_W'(1)) : rd_ptr_ff;
      issued_in     = rd_en;
      issued_idx_in = rd_addr;
      is_deq_in     = is_deq_ff;
      res_take_in   = res_take_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_take_in   = 1'b0;
               res_status_in = apq_pkg::STAT_OK;
               state_in      = S_DONE;
               priority if (req_cmd == apq_pkg::CMD_ENQ) begin
                  if (cnt_ff < CNT_W'(QUEUE_DEPTH)) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     res_status_in = apq_pkg::STAT_OVERFLOW;
                  end
               end else if ((req_cmd == apq_pkg::CMD_DEQ) ||
                            (req_cmd == apq_pkg::CMD_PEEK)) begin
                  if (cnt_ff == '0) begin
                     res_status_in = apq_pkg::STAT_EMPTY;
                  end else begin
                     is_deq_in   = (req_cmd == apq_pkg::CMD_DEQ);
                     res_take_in = 1'b1;
                     rd_ptr_in   = '0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  res_status_in = apq_pkg::STAT_OK;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = is_deq_ff ? S_PICK : S_DONE;
            end
         end
         S_PICK: begin
            rd_ptr_in = CNT_W'(best_idx) + CNT_W'(1);
            state_in  = S_SHIFT;
         end
         S_SHIFT: begin
            if (shift_done) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         rd_ptr_ff <= '0;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         issued_ff <= issued_in;
      end
   end

   // Per-request bookkeeping
   always_ff @(posedge clock) begin
      issued_idx_ff <= issued_idx_in;
      is_deq_ff     <= is_deq_in;
      res_take_ff   <= res_take_in;
      res_status_ff <= res_status_in;
   end

   // Output register: hold a beat until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_status_ff   <= res_status_ff;
         rsp_value_ff    <= res_take_ff ? best_value : '0;
         rsp_priority_ff <= res_take_ff ? best_priority : '0;
         rsp_count_ff    <= apq_pkg::COUNT_OUT_W'(cnt_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_priority_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // Assertions
   `APQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH),
                    "entry count above queue depth")
   `APQ_ASSERT_NEXT(a_deq_scans,
                    req_fire && (req_cmd == apq_pkg::CMD_DEQ) && (cnt_ff != '0),
                    state_ff == S_SCAN, "dequeue on a held entry did not start a scan")
   `APQ_ASSERT_SAME(a_shift_in_range, (state_ff == S_SHIFT) && wr_en,
                    (CNT_W'(wr_addr) + CNT_W'(1)) < cnt_ff,
                    "shift writes beyond the held entries")
   `APQ_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_ff),
                    $past(state_ff == S_DONE), "result raised outside completion")

endmodule

>>> dv/array_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// array_priority_queue_checker
// Watches the request and result channels of the priority queue, keeps its
// own copy of the held entries and compares each result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_priority_queue_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [apq_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [apq_pkg::DATA_W-1:0] req_item_value,
   input  logic signed [apq_pkg::DATA_W-1:0] req_item_priority,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_status,
   input  logic signed [apq_pkg::DATA_W-1:0] rsp_out_value,
   input  logic signed [apq_pkg::DATA_W-1:0] rsp_out_priority,
   input  logic [apq_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output int                                error_count,
   output int                                pending_beats
);

   typedef struct packed {
      apq_pkg::status_type                status;
      logic signed [apq_pkg::DATA_W-1:0]  value;
      logic signed [apq_pkg::DATA_W-1:0]  prio;
      logic [apq_pkg::COUNT_OUT_W-1:0]    count;
   } queue_result_type;

   // Shadow copy of the queue contents
   logic signed [apq_pkg::DATA_W-1:0] held_value [QUEUE_DEPTH];
   logic signed [apq_pkg::DATA_W-1:0] held_prio  [QUEUE_DEPTH];
   int                                held_count;

   queue_result_type expected_results [$];
   int               mismatch_total = 0;
   int               pending_total  = 0;

   assign error_count   = mismatch_total;
   assign pending_beats = pending_total;

   // Apply one command to the shadow queue and return the result it gives
   function automatic queue_result_type apply_queue_op(
      input logic [apq_pkg::CMD_W-1:0]         cmd,
      input logic signed [apq_pkg::DATA_W-1:0] val,
      input logic signed [apq_pkg::DATA_W-1:0] pri);
      queue_result_type r;
      int               best;
      r        = '0;
      r.status = apq_pkg::STAT_OK;
      case (cmd)
         apq_pkg::CMD_ENQ: begin
            if (held_count >= QUEUE_DEPTH) begin
               r.status = apq_pkg::STAT_OVERFLOW;
            end else begin
               held_value[held_count] = val;
               held_prio[held_count]  = pri;
               held_count++;
            end
         end
         apq_pkg::CMD_DEQ, apq_pkg::CMD_PEEK: begin
            if (held_count == 0) begin
               r.status = apq_pkg::STAT_EMPTY;
            end else begin
               // scan for the largest priority, oldest entry wins a tie
               best = 0;
               for (int i = 1; i < held_count; i++) begin
                  if (held_prio[i] > held_prio[best]) best = i;
               end
               r.value = held_value[best];
               r.prio  = held_prio[best];
               if (cmd == apq_pkg::CMD_DEQ) begin
                  // close the gap left by the winner
                  for (int i = best; i < held_count - 1; i++) begin
                     held_value[i] = held_value[i + 1];
                     held_prio[i]  = held_prio[i + 1];
                  end
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      r.count = held_count[apq_pkg::COUNT_OUT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [apq_pkg::DATA_W-1:0] want,
                              input logic [apq_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_total++;
      end
   endtask

   // Compare result beats first, then record the new request beat
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, status %0d value %0h",
                        $time, rsp_status, rsp_out_value);
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_value", want.value, rsp_out_value);
               check_field("out_priority", want.prio, rsp_out_priority);
               check_field("entry_count", want.count, rsp_entry_count);
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_queue_op(req_cmd, req_item_value,
                                                      req_item_priority));
         end
      end
      pending_total <= expected_results.size();
   end

endmodule

>>> dv/array_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// array_priority_queue_tb
// Drives enqueue, dequeue, peek and spare commands into the priority queue
// with random idle bursts on both channels and one long result hold-off;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_priority_queue_tb;

   localparam int                        DEPTH        = 16;
   localparam int                        RANDOM_BEATS = 1625;
   localparam int                        CYCLE_LIMIT  = 600000;
   localparam int                        LONG_HOLD    = 120;
   localparam int                        TAIL_CYCLES  = 40;
   localparam logic [apq_pkg::CMD_W-1:0] CMD_SPARE    = 2'd3;
   localparam logic signed [apq_pkg::DATA_W-1:0] MIN_WORD = 32'sh8000_0000;
   localparam logic signed [apq_pkg::DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;

   logic                              clock             = 1'b0;
   logic                              reset             = 1'b1;
   logic                              req_valid         = 1'b0;
   logic                              req_stall;
   logic [apq_pkg::CMD_W-1:0]         req_cmd           = apq_pkg::CMD_ENQ;
   logic signed [apq_pkg::DATA_W-1:0] req_item_value    = '0;
   logic signed [apq_pkg::DATA_W-1:0] req_item_priority = '0;
   logic                              rsp_valid;
   logic                              rsp_stall         = 1'b0;
   logic [1:0]                        rsp_status;
   logic signed [apq_pkg::DATA_W-1:0] rsp_out_value;
   logic signed [apq_pkg::DATA_W-1:0] rsp_out_priority;
   logic [apq_pkg::COUNT_OUT_W-1:0]   rsp_entry_count;

   int error_count;
   int pending_beats;
   int cycle_count = 0;
   bit hold_go     = 1'b0;
   bit hold_done   = 1'b0;
   bit quiet       = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   array_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_entry_count   (rsp_entry_count)
   );

   array_priority_queue_checker #(
      .QUEUE_DEPTH(DEPTH)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_entry_count   (rsp_entry_count),
      .error_count       (error_count),
      .pending_beats     (pending_beats)
   );

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("array_priority_queue verification failed");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off, none at the end
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request beat and hold it until the block takes it
   task automatic send_beat(input logic [apq_pkg::CMD_W-1:0] cmd,
                            input logic signed [apq_pkg::DATA_W-1:0] val,
                            input logic signed [apq_pkg::DATA_W-1:0] pri);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_item_value    <= val;
      req_item_priority <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int                                mode;
      int                                pick;
      int                                enq_share;
      logic [apq_pkg::CMD_W-1:0]         op;
      logic signed [apq_pkg::DATA_W-1:0] val;
      logic signed [apq_pkg::DATA_W-1:0] pri;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: dequeue, peek and the spare command
      send_beat(apq_pkg::CMD_DEQ, $urandom, $urandom);
      send_beat(apq_pkg::CMD_PEEK, $urandom, $urandom);
      send_beat(CMD_SPARE, $urandom, $urandom);

      // Fill to the brim with extreme values and tied priorities
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       val = MIN_WORD;
            1:       val = MAX_WORD;
            2:       val = '0;
            3:       val = -1;
            default: val = $urandom;
         endcase
         case (i % 8)
            0:       pri = '0;
            1:       pri = MIN_WORD;
            2:       pri = MAX_WORD;
            3:       pri = -1;
            4, 5:    pri = 7;
            6:       pri = -5;
            default: pri = 1;
         endcase
         send_beat(apq_pkg::CMD_ENQ, val, pri);
      end

      // Full queue: overflow, spare, then serve ties oldest first
      send_beat(apq_pkg::CMD_ENQ, $urandom, $urandom);
      send_beat(CMD_SPARE, $urandom, $urandom);
      send_beat(apq_pkg::CMD_PEEK, $urandom, $urandom);
      repeat (3) send_beat(apq_pkg::CMD_DEQ, $urandom, $urandom);

      // Random traffic in fill, drain and balanced stretches
      mode = 2;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 50 == 0) mode = $urandom_range(0, 2);
         if (n == 300) hold_go = 1'b1;
         if (n == RANDOM_BEATS - 150) quiet = 1'b1;
         enq_share = (mode == 0) ? 70 : (mode == 1) ? 30 : 50;
         pick      = $urandom_range(0, 99);
         if (pick < 2) op = CMD_SPARE;
         else if (pick < enq_share) op = apq_pkg::CMD_ENQ;
         else if (pick < enq_share + (100 - enq_share) * 2 / 3) op = apq_pkg::CMD_DEQ;
         else op = apq_pkg::CMD_PEEK;
         val = $urandom;
         case ($urandom_range(0, 3))
            0, 1: begin
               pri = $urandom_range(0, 6);
               pri = pri - 3;
            end
            2:    pri = $urandom;
            default: begin
               case ($urandom_range(0, 3))
                  0:       pri = MIN_WORD;
                  1:       pri = MAX_WORD;
                  2:       pri = '0;
                  default: pri = -1;
               endcase
            end
         endcase
         send_beat(op, val, pri);
      end
      req_valid <= 1'b0;

      // Drain, then let the block settle
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_beats == 0) begin
         $display("array_priority_queue verification clean");
      end else begin
         $display("array_priority_queue verification failed");
      end
      $finish;
   end

endmodule
